### sv/lzw_pkg.sv
// shared types and constants of the lzw encoder
// no dependencies; used by lzw_out_fifo, lzw_encoder and the testbench
package lzw_pkg;

    // dictionary geometry
    localparam int DICT_SIZE  = 1024;
    localparam int ROOT_CODES = 27;
    localparam int CODE_W     = $clog2(DICT_SIZE);
    localparam int NFC_W      = CODE_W + 1;
    localparam int SLOT_W     = CODE_W + 1;
    localparam int HASH_DEPTH = 2 ** SLOT_W;

    // payload widths
    localparam int SYM_W      = 5;
    localparam int OUT_CODE_W = 10;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [NFC_W-1:0]  nfc_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [SYM_W-1:0]  sym_t;

    typedef struct packed {
        sym_t symbol;
        logic last_symbol;
    } in_t;

    typedef struct packed {
        logic [OUT_CODE_W-1:0] out_code;
        logic                  last_code;
    } out_t;

    // result queue status seen by the encoder control
    typedef struct packed {
        logic room2;
        logic full;
    } fifo_status_t;

endpackage

### sv/lzw_encoder.sv
// lzw encoder top level: control, hash table and entry memory
// depends on lzw_pkg and lzw_out_fifo
//
// LZW encoder over the alphabet '#' (0) and 'A'..'Z' (1..26); symbols 27..31 are read as '#'.
// Learned entries are found through a hash table of 2*DICT_SIZE slots (linear probing) that
// points into an entry memory holding prefix, symbol and owning slot of each code. A slot
// counts as occupied only if its code is a learned code of the current text and that entry
// names the slot back, so no clearing is needed between texts. A symbol is taken in the idle
// state; each probe then reads the hash slot, reads the entry and compares, through the two
// memory read ports; the table is at most half full. The first symbol of a text needs no probe,
// and a final symbol adds a flush step. After reset the hash table is swept once, one slot per
// cycle, all 2048 slots at the default size, while s_ready stays low. Results wait in a
// four-entry queue; a symbol is taken whenever the control is idle and the queue has room
// for two results.
module lzw_encoder (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lzw_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lzw_pkg::out_t m_data
);

    localparam int OUT_WIDE = (lzw_pkg::CODE_W > lzw_pkg::OUT_CODE_W) ?
                              lzw_pkg::CODE_W : lzw_pkg::OUT_CODE_W;

    typedef enum logic [5:0] {
        ST_CLEAR    = 6'b000001,
        ST_IDLE     = 6'b000010,
        ST_RD_HASH  = 6'b000100,
        ST_RD_ENTRY = 6'b001000,
        ST_CHECK    = 6'b010000,
        ST_FLUSH    = 6'b100000
    } state_t;

    typedef struct packed {
        lzw_pkg::code_t prefix;
        lzw_pkg::sym_t  symbol;
        lzw_pkg::slot_t slot;
    } entry_t;

    // hash of a prefix and symbol pair into a table slot
    function automatic lzw_pkg::slot_t slot_hash(lzw_pkg::code_t pfx, lzw_pkg::sym_t sym);
        lzw_pkg::slot_t p;
        lzw_pkg::slot_t s;
        p = lzw_pkg::slot_t'(pfx);
        s = lzw_pkg::slot_t'(sym);
        return p ^ (s << (lzw_pkg::SLOT_W - lzw_pkg::SYM_W)) ^ s;
    endfunction

    // code as carried on the result channel (low bits)
    function automatic logic [lzw_pkg::OUT_CODE_W-1:0] to_out(lzw_pkg::code_t code);
        logic [OUT_WIDE-1:0] wide;
        wide = OUT_WIDE'(code);
        return wide[lzw_pkg::OUT_CODE_W-1:0];
    endfunction

    state_t         state_reg, state_next;
    lzw_pkg::code_t prefix_reg, prefix_next;
    logic           prefix_valid_reg, prefix_valid_next;
    lzw_pkg::nfc_t  nfc_reg, nfc_next;
    lzw_pkg::sym_t  sym_reg, sym_next;
    logic           last_reg, last_next;
    lzw_pkg::slot_t slot_reg, slot_next;
    lzw_pkg::slot_t clr_reg, clr_next;

    // memories
    lzw_pkg::code_t hash_mem [lzw_pkg::HASH_DEPTH];
    entry_t         entry_mem [lzw_pkg::DICT_SIZE];
    lzw_pkg::code_t hash_rdata_reg;
    entry_t         entry_rdata_reg;
    logic           hash_we;
    lzw_pkg::slot_t hash_waddr;
    lzw_pkg::code_t hash_wdata;
    logic           entry_we;
    entry_t         entry_wdata;

    logic                  s_accept;
    lzw_pkg::sym_t         sym_in;
    logic                  occupied;
    logic                  hit;
    logic                  dict_room;
    logic                  push;
    lzw_pkg::out_t         push_data;
    lzw_pkg::fifo_status_t fifo_status;

    assign s_ready  = (state_reg == ST_IDLE) && fifo_status.room2;
    assign s_accept = s_valid && s_ready;
    assign sym_in   = (s_data.symbol >= lzw_pkg::SYM_W'(lzw_pkg::ROOT_CODES)) ?
                      '0 : s_data.symbol;

    // probe result: the slot belongs to a learned code of this text
    assign occupied = (lzw_pkg::nfc_t'(hash_rdata_reg) >= lzw_pkg::nfc_t'(lzw_pkg::ROOT_CODES))
                   && (lzw_pkg::nfc_t'(hash_rdata_reg) < nfc_reg)
                   && (entry_rdata_reg.slot == slot_reg);
    assign hit      = occupied && (entry_rdata_reg.prefix == prefix_reg)
                   && (entry_rdata_reg.symbol == sym_reg);
    assign dict_room = nfc_reg < lzw_pkg::nfc_t'(lzw_pkg::DICT_SIZE);

    // control sequencer
    always_comb begin
        state_next        = state_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        nfc_next          = nfc_reg;
        sym_next          = sym_reg;
        last_next         = last_reg;
        slot_next         = slot_reg;
        clr_next          = clr_reg;
        hash_we           = 1'b0;
        hash_waddr        = slot_reg;
        hash_wdata        = nfc_reg[lzw_pkg::CODE_W-1:0];
        entry_we          = 1'b0;
        entry_wdata       = '{prefix: prefix_reg, symbol: sym_reg, slot: slot_reg};
        push              = 1'b0;
        push_data         = '{out_code: to_out(prefix_reg), last_code: 1'b0};
        case (state_reg)
            ST_CLEAR: begin
                hash_we    = 1'b1;
                hash_waddr = clr_reg;
                hash_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    sym_next  = sym_in;
                    last_next = s_data.last_symbol;
                    if (!prefix_valid_reg) begin
                        prefix_next       = lzw_pkg::code_t'(sym_in);
                        prefix_valid_next = 1'b1;
                        state_next        = s_data.last_symbol ? ST_FLUSH : ST_IDLE;
                    end else begin
                        slot_next  = slot_hash(prefix_reg, sym_in);
                        state_next = ST_RD_HASH;
                    end
                end
            end
            ST_RD_HASH: begin
                state_next = ST_RD_ENTRY;
            end
            ST_RD_ENTRY: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (hit) begin
                    prefix_next = hash_rdata_reg;
                    state_next  = last_reg ? ST_FLUSH : ST_IDLE;
                end else if (occupied) begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_RD_HASH;
                end else begin
                    // miss: emit prefix, learn the new entry in the free slot if the dictionary has room
                    push = 1'b1;
                    if (dict_room) begin
                        hash_we  = 1'b1;
                        entry_we = 1'b1;
                        nfc_next = nfc_reg + 1'b1;
                    end
                    prefix_next = lzw_pkg::code_t'(sym_reg);
                    state_next  = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                push              = 1'b1;
                push_data         = '{out_code: to_out(prefix_reg), last_code: 1'b1};
                prefix_valid_next = 1'b0;
                prefix_next       = '0;
                nfc_next          = lzw_pkg::nfc_t'(lzw_pkg::ROOT_CODES);
                state_next        = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            nfc_reg          <= lzw_pkg::nfc_t'(lzw_pkg::ROOT_CODES);
            clr_reg          <= '0;
        end else begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            nfc_reg          <= nfc_next;
            clr_reg          <= clr_next;
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        sym_reg  <= sym_next;
        last_reg <= last_next;
        slot_reg <= slot_next;
    end

    // hash table: slot to code
    always_ff @(posedge aclk) begin
        if (hash_we) begin
            hash_mem[hash_waddr] <= hash_wdata;
        end
        hash_rdata_reg <= hash_mem[slot_reg];
    end

    // entry memory: code to prefix, symbol and owning slot
    always_ff @(posedge aclk) begin
        if (entry_we) begin
            entry_mem[nfc_reg[lzw_pkg::CODE_W-1:0]] <= entry_wdata;
        end
        entry_rdata_reg <= entry_mem[hash_rdata_reg];
    end

    lzw_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .status    (fifo_status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_status.full)
        else $error("result queue overflow");

    a_first_no_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !prefix_valid_reg) |=> (state_reg != ST_RD_HASH))
        else $error("probe started without a prefix");

    a_flush_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |=>
            (!prefix_valid_reg && nfc_reg == lzw_pkg::nfc_t'(lzw_pkg::ROOT_CODES)))
        else $error("dictionary not restarted after final code");

    a_hit_takes_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && hit) |=> (prefix_reg == $past(hash_rdata_reg)))
        else $error("matched code not taken as prefix");

endmodule

### sv/lzw_out_fifo.sv
// small result queue between the encoder control and the m_ channel
// depends on lzw_pkg
module lzw_out_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lzw_pkg::out_t         push_data,
    output lzw_pkg::fifo_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lzw_pkg::out_t         m_data
);

    lzw_pkg::out_t                   queue_reg [lzw_pkg::FIFO_DEPTH];
    logic [lzw_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lzw_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lzw_pkg::FIFO_PTR_W:0]    count_reg, count_next;
    logic                            pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = count_reg != '0;
    assign m_data  = queue_reg[rd_ptr_reg];

    // room for the up to two results of one item
    assign status.room2 = count_reg <= (lzw_pkg::FIFO_PTR_W + 1)'(lzw_pkg::FIFO_DEPTH - 2);
    assign status.full  = count_reg == (lzw_pkg::FIFO_PTR_W + 1)'(lzw_pkg::FIFO_DEPTH);

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the lzw encoder: predicts every emitted code
// depends on lzw_pkg and lzw_encoder
module testbench;
    import lzw_pkg::*;

    // alphabet codes used by the directed texts
    localparam sym_t SYM_HASH = 5'd0;
    localparam sym_t SYM_A    = 5'd1;
    localparam sym_t SYM_B    = 5'd2;
    localparam sym_t SYM_Z    = 5'd26;
    localparam sym_t SYM_MAX  = 5'd31;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;

    lzw_encoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // predicted encoder state
    int   dict_prefix [DICT_SIZE];
    sym_t dict_symbol [DICT_SIZE];
    int   next_code;
    int   cur_prefix;
    bit   have_prefix;

    out_t expected_codes[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int error_count;
    int symbols_sent;
    int texts_sent;
    int codes_checked;
    int dict_fills;

    // clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predict the codes that one symbol transfer causes
    function automatic void predict_symbol(input sym_t raw, input logic fin);
        sym_t s;
        int   hit;
        out_t r;
        s = (raw >= ROOT_CODES) ? SYM_HASH : raw;
        if (!have_prefix) begin
            cur_prefix  = s;
            have_prefix = 1'b1;
        end else begin
            hit = -1;
            for (int c = ROOT_CODES; c < next_code; c++) begin
                if (dict_prefix[c] == cur_prefix && dict_symbol[c] == s) begin
                    hit = c;
                    break;
                end
            end
            if (hit >= 0) begin
                cur_prefix = hit;
            end else begin
                r.out_code  = OUT_CODE_W'(cur_prefix);
                r.last_code = 1'b0;
                expected_codes.push_back(r);
                if (next_code < DICT_SIZE) begin
                    dict_prefix[next_code] = cur_prefix;
                    dict_symbol[next_code] = s;
                    next_code++;
                    if (next_code == DICT_SIZE) dict_fills++;
                end
                cur_prefix = s;
            end
        end
        // end of text flushes the prefix and restarts the dictionary
        if (fin) begin
            r.out_code  = OUT_CODE_W'(cur_prefix);
            r.last_code = 1'b1;
            expected_codes.push_back(r);
            have_prefix = 1'b0;
            cur_prefix  = 0;
            next_code   = ROOT_CODES;
            texts_sent++;
        end
    endfunction

    // a symbol that extends the current prefix to a phrase not learned yet, if any
    function automatic sym_t pick_unlearned();
        bit [ROOT_CODES-1:0] used;
        int                  start;
        int                  s;
        used  = '0;
        start = $urandom_range(0, ROOT_CODES - 1);
        if (have_prefix) begin
            for (int c = ROOT_CODES; c < next_code; c++) begin
                if (dict_prefix[c] == cur_prefix) used[dict_symbol[c]] = 1'b1;
            end
        end
        for (int k = 0; k < ROOT_CODES; k++) begin
            s = (start + k) % ROOT_CODES;
            if (!used[s]) return sym_t'(s);
        end
        return sym_t'(start);
    endfunction

    // one symbol transfer; entered and left at a falling edge
    task automatic send_symbol(input sym_t sym, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = '{symbol: sym, last_symbol: fin};
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_symbol(sym, fin);
        symbols_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // random text; the alphabet size shapes how long the phrases grow
    task automatic send_random_text(input int len);
        int   pick;
        sym_t sym;
        pick = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            case (pick)
                0: sym = sym_t'($urandom_range(0, 1));
                1: sym = sym_t'($urandom_range(0, 3));
                2: sym = sym_t'($urandom_range(0, 26));
                default: sym = sym_t'($urandom);
            endcase
            send_symbol(sym, i == len - 1);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_codes.size() == 0) begin
                $error("unexpected code transfer: out_code %0d last_code %0d",
                       m_data.out_code, m_data.last_code);
                error_count++;
            end else begin
                want = expected_codes.pop_front();
                codes_checked++;
                if (m_data.out_code !== want.out_code) begin
                    $error("out_code expected %0d actual %0d", want.out_code, m_data.out_code);
                    error_count++;
                end
                if (m_data.last_code !== want.last_code) begin
                    $error("last_code expected %0d actual %0d",
                           want.last_code, m_data.last_code);
                    error_count++;
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // a text of one symbol is flushed at once, whatever the symbol
    task automatic test_lone_symbols();
        send_symbol(SYM_HASH, 1'b1);
        send_symbol(SYM_Z, 1'b1);
        send_symbol(SYM_MAX, 1'b1);
    endtask

    // repeated symbols and pairs grow learned phrases; final symbol hits an entry
    task automatic test_phrase_growth();
        for (int i = 0; i < 6; i++) send_symbol(SYM_A, i == 5);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_B, 1'b0);
        send_symbol(SYM_A, 1'b0);
        send_symbol(SYM_B, 1'b1);
    endtask

    // symbols past 'Z' encode as '#'
    task automatic test_out_of_range();
        send_symbol(SYM_HASH, 1'b0);
        for (int v = ROOT_CODES; v <= SYM_MAX; v++) send_symbol(sym_t'(v), 1'b0);
        send_symbol(SYM_HASH, 1'b1);
    endtask

    // one long text that fills the dictionary and keeps encoding after that
    task automatic test_dictionary_full();
        while (next_code < DICT_SIZE) send_symbol(pick_unlearned(), 1'b0);
        for (int i = 0; i < 50; i++) send_symbol(sym_t'($urandom_range(0, 26)), i == 49);
    endtask

    // receiver holds off while the sender keeps offering symbols
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) send_symbol(sym_t'($urandom_range(0, 26)), i == 39);
        while (hold_request) @(negedge aclk);
    endtask

    // random texts under one idling setting
    task automatic test_random_texts(input int s_pct, input int r_pct, input int count);
        int target;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = symbols_sent + count;
        while (symbols_sent < target) begin
            if ($urandom_range(0, 9) == 0) send_random_text($urandom_range(100, 300));
            else send_random_text($urandom_range(1, 30));
        end
    endtask

    // main sequence
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        hold_request  = 1'b0;
        error_count   = 0;
        symbols_sent  = 0;
        texts_sent    = 0;
        codes_checked = 0;
        dict_fills    = 0;
        next_code     = ROOT_CODES;
        cur_prefix    = 0;
        have_prefix   = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 73;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_lone_symbols();
        test_phrase_growth();
        test_out_of_range();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_dictionary_full();
        test_backpressure();
        test_random_texts(25, 73, 40);
        test_random_texts(73, 25, 40);
        test_random_texts(0, 0, 40);

        s_valid = 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d symbols in %0d texts, %0d codes checked", symbols_sent,
                 texts_sent, codes_checked);
        $display("dictionary filled %0d times, receiver hold-off of %0d cycles", dict_fills,
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
